### hw/rtl/sbars_pkg.sv
package sbars_pkg;

  localparam int NumBins       = 1024;
  localparam int AddrW         = $clog2(NumBins);
  localparam int BinW          = 10;
  localparam int MagW          = 32;
  localparam int DbW           = 16;
  localparam int CoefW         = 16;
  localparam int CfgIdxW       = 2;
  localparam int CfgDataW      = 16;
  localparam int LogTableDepth = 64;
  localparam int LogIdxW       = $clog2(LogTableDepth);
  localparam int LogFracW      = 16;
  localparam int LogEntW       = LogFracW + 1;
  localparam int PosW          = $clog2(MagW);
  localparam int L2W           = PosW + 1 + LogFracW;
  localparam int DbPerLog2W    = 19;
  localparam int DbProdW       = L2W + DbPerLog2W + 1;
  localparam int DbShift       = 24;
  localparam int FiltProdW     = CoefW + 1 + DbW + 1;
  localparam int FiltShift     = CoefW;

  // 20*log10(2) in Q3.16
  localparam logic [DbPerLog2W-1:0] DbPerLog2 = 19'd394566;

  localparam logic [CoefW-1:0]      ResetAttack = 16'd0;
  localparam logic [CoefW-1:0]      ResetDecay  = 16'd58982;
  localparam logic signed [DbW-1:0] ResetMinDb  = -16'sd23040;
  localparam logic signed [DbW-1:0] ResetMaxDb  = 16'sd3072;

  typedef enum logic [CfgIdxW-1:0] {
    CfgAttack = 2'd0,
    CfgDecay  = 2'd1,
    CfgMinDb  = 2'd2,
    CfgMaxDb  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic            action;
    logic [BinW-1:0] bin_index;
    logic [MagW-1:0] magnitude;
  } in_word_t;

  typedef struct packed {
    logic [BinW-1:0]       out_bin_index;
    logic signed [DbW-1:0] smoothed_db;
  } out_word_t;

  typedef logic [LogEntW-1:0] log_ent_t;
  typedef log_ent_t log_rom_t [LogTableDepth];

  // log2(1 + i/depth) in Q0.16 by repeated squaring
  function automatic log_ent_t log_entry(int unsigned i);
    logic [63:0] x;
    logic [16:0] r;
    x = ((64'(LogTableDepth) + 64'(i)) << 30) / LogTableDepth;
    r = '0;
    for (int k = 0; k < 17; k++) begin
      x = (x * x) >> 30;
      r = {r[15:0], 1'b0};
      if (x >= 64'h8000_0000) begin
        x    = x >> 1;
        r[0] = 1'b1;
      end
    end
    return log_ent_t'((18'(r) + 18'd1) >> 1);
  endfunction

  function automatic log_rom_t build_log_rom();
    log_rom_t rom;
    for (int i = 0; i < LogTableDepth; i++) begin
      rom[i] = log_entry(i);
    end
    return rom;
  endfunction

  localparam log_rom_t LogRom = build_log_rom();

endpackage

### hw/rtl/spectrum_bin_attack_release_smoother.sv
// Throughput: one word per cycle while the output accepts words; a word for the
// same bin as the word just ahead of it waits until that word is written to the level memory.
// Reset: config registers take their reset values, then a clearing pass writes
// -90 dB into each of the 1024 bins while in_ready_o stays low.
module spectrum_bin_attack_release_smoother (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  sbars_pkg::in_word_t               in_word_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output sbars_pkg::out_word_t              out_word_o,
  input  logic                              cfg_we_i,
  input  logic [sbars_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [sbars_pkg::CfgDataW-1:0]    cfg_wdata_i
);
  import sbars_pkg::*;

  // config
  logic [CoefW-1:0]      attack_q, decay_q;
  logic signed [DbW-1:0] min_db_q, max_db_q;

  // clearing pass
  logic             clr_busy_q;
  logic [AddrW-1:0] clr_cnt_q;

  // stage A: input word
  logic                 a_v_q, a_act_q;
  logic [BinW-1:0]      a_bin_q;
  logic [MagW-1:0]      a_mag_q;
  logic [MagW-1:0]      a_mag_nz;
  logic [PosW-1:0]      a_pos;

  // stage B: leading-one position
  logic                 b_v_q, b_act_q;
  logic [BinW-1:0]      b_bin_q;
  logic [MagW-1:0]      b_mag_q;
  logic [PosW-1:0]      b_pos_q;
  logic [MagW-1:0]      b_norm;
  logic [LogIdxW-1:0]   b_idx;
  logic signed [PosW:0] b_exp;
  logic [L2W-1:0]       b_l2;

  // stage C: log2 in signed Q6.16
  logic                      c_v_q, c_act_q;
  logic [BinW-1:0]           c_bin_q;
  logic signed [L2W-1:0]     c_l2_q;
  logic signed [DbProdW-1:0] c_prod, c_sum;

  // stage R: dB value and stored level
  logic                  r_v_q, r_act_q;
  logic [BinW-1:0]       r_bin_q;
  logic signed [DbW-1:0] r_db_q, r_prev, r_db_c;
  logic [DbW-1:0]        rdata_q;
  logic [CoefW-1:0]      r_coef;
  logic signed [DbW:0]   r_diff;

  // stage M: filter and write back
  logic                        m_v_q;
  logic [BinW-1:0]             m_bin_q;
  logic signed [DbW-1:0]       m_db_q, m_res;
  logic [CoefW-1:0]            m_coef_q;
  logic signed [DbW:0]         m_diff_q;
  logic signed [FiltProdW-1:0] m_prod, m_sum, m_adj;

  // output
  logic      out_v_q;
  out_word_t out_word_q;

  // level memory and last write for forwarding
  logic [DbW-1:0]   level_mem [NumBins];
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [DbW-1:0]   mem_wdata;
  logic             wr_v_q;
  logic [AddrW-1:0] wr_addr_q;
  logic [DbW-1:0]   wr_data_q;

  // handshake
  logic out_en, m_go, m_free, hazard, r_go, r_free, c_go, c_free, b_go, b_free;
  logic a_go, a_free, in_acc;

  assign out_en = !out_v_q || out_ready_i;
  assign m_go   = m_v_q && out_en;
  assign m_free = !m_v_q || out_en;
  assign hazard = r_v_q && m_v_q && (r_bin_q[AddrW-1:0] == m_bin_q[AddrW-1:0]);
  assign r_go   = r_v_q && m_free && !hazard;
  assign r_free = !r_v_q || r_go;
  assign c_go   = c_v_q && r_free;
  assign c_free = !c_v_q || c_go;
  assign b_go   = b_v_q && c_free;
  assign b_free = !b_v_q || b_go;
  assign a_go   = a_v_q && b_free;
  assign a_free = !a_v_q || a_go;

  assign in_ready_o  = a_free && !clr_busy_q;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_v_q;
  assign out_word_o  = out_word_q;

  // stage A: leading one
  always_comb begin
    a_mag_nz = (a_mag_q == '0) ? MagW'(1) : a_mag_q;
    a_pos    = '0;
    for (int k = 0; k < MagW; k++) begin
      if (a_mag_nz[k]) begin
        a_pos = PosW'(k);
      end
    end
  end

  // stage B: normalize, table lookup
  always_comb begin
    b_norm = b_mag_q << (PosW'(MagW - 1) - b_pos_q);
    b_idx  = b_norm[MagW-2 -: LogIdxW];
    b_exp  = $signed({1'b0, b_pos_q}) - $signed((PosW + 1)'(16));
    b_l2   = {b_exp, {LogFracW{1'b0}}} + L2W'(LogRom[b_idx]);
  end

  // stage C: scale to dB
  always_comb begin
    c_prod = c_l2_q * $signed({1'b0, DbPerLog2});
    c_sum  = c_prod + $signed(DbProdW'(1) << (DbShift - 1));
  end

  // stage R: clamp, pick coefficient
  always_comb begin
    r_prev = (wr_v_q && wr_addr_q == r_bin_q[AddrW-1:0]) ? $signed(wr_data_q)
                                                          : $signed(rdata_q);
    if (r_db_q < min_db_q) begin
      r_db_c = min_db_q;
    end else if (r_db_q > max_db_q) begin
      r_db_c = max_db_q;
    end else begin
      r_db_c = r_db_q;
    end
    r_coef = (r_db_c > r_prev) ? attack_q : decay_q;
    r_diff = {r_prev[DbW-1], r_prev} - {r_db_c[DbW-1], r_db_c};
  end

  // stage M: new = db + round(c * (prev - db) / 2^16)
  always_comb begin
    m_prod = $signed({1'b0, m_coef_q}) * m_diff_q;
    m_sum  = m_prod + $signed(FiltProdW'(1) << (FiltShift - 1));
    m_adj  = m_sum >>> FiltShift;
    m_res  = m_db_q + $signed(DbW'(m_adj));
  end

  assign mem_we    = clr_busy_q || m_go;
  assign mem_waddr = clr_busy_q ? clr_cnt_q : m_bin_q[AddrW-1:0];
  assign mem_wdata = clr_busy_q ? ResetMinDb : m_res;
  assign mem_raddr = c_go ? c_bin_q[AddrW-1:0] : r_bin_q[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      level_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= level_mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q   <= ResetAttack;
      decay_q    <= ResetDecay;
      min_db_q   <= ResetMinDb;
      max_db_q   <= ResetMaxDb;
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
      a_v_q      <= 1'b0;
      b_v_q      <= 1'b0;
      c_v_q      <= 1'b0;
      r_v_q      <= 1'b0;
      m_v_q      <= 1'b0;
      out_v_q    <= 1'b0;
      wr_v_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CfgAttack: attack_q <= cfg_wdata_i;
          CfgDecay:  decay_q  <= cfg_wdata_i;
          CfgMinDb:  min_db_q <= $signed(cfg_wdata_i);
          CfgMaxDb:  max_db_q <= $signed(cfg_wdata_i);
          default:   ;
        endcase
      end
      if (clr_busy_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == AddrW'(NumBins - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      a_v_q   <= in_acc || (a_v_q && !a_go);
      b_v_q   <= a_go || (b_v_q && !b_go);
      c_v_q   <= b_go || (c_v_q && !c_go);
      r_v_q   <= c_go || (r_v_q && !r_go);
      m_v_q   <= r_go || (m_v_q && !m_go);
      if (out_en) begin
        out_v_q <= m_v_q;
      end
      wr_v_q  <= mem_we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_act_q <= in_word_i.action;
      a_bin_q <= in_word_i.bin_index;
      a_mag_q <= in_word_i.magnitude;
    end
    if (a_go) begin
      b_act_q <= a_act_q;
      b_bin_q <= a_bin_q;
      b_mag_q <= a_mag_nz;
      b_pos_q <= a_pos;
    end
    if (b_go) begin
      c_act_q <= b_act_q;
      c_bin_q <= b_bin_q;
      c_l2_q  <= $signed(b_l2);
    end
    if (c_go) begin
      r_act_q <= c_act_q;
      r_bin_q <= c_bin_q;
      r_db_q  <= $signed(DbW'(c_sum >>> DbShift));
    end
    if (r_go) begin
      m_bin_q  <= r_bin_q;
      // clear: coefficient and difference of zero leave min_db as the result
      m_db_q   <= r_act_q ? min_db_q : r_db_c;
      m_coef_q <= r_act_q ? '0 : r_coef;
      m_diff_q <= r_act_q ? '0 : r_diff;
    end
    if (m_go) begin
      out_word_q.out_bin_index <= m_bin_q;
      out_word_q.smoothed_db   <= m_res;
    end
    wr_addr_q <= mem_waddr;
    wr_data_q <= mem_wdata;
  end

endmodule

### dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sbars_pkg::*;

  localparam int LogSteps   = 64;
  localparam int CycleLimit = 400000;
  localparam int DrainWait  = 8;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  in_word_t  in_word = '0;
  logic      out_ready = 1'b0;
  logic      cfg_we = 1'b0;
  cfg_idx_e  cfg_idx = CfgAttack;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  logic      in_ready;
  logic      out_valid;
  out_word_t out_word;

  // predictor copy of the registers and the per-bin levels
  int attack_w = ResetAttack;
  int decay_w  = ResetDecay;
  int lo_db    = ResetMinDb;
  int hi_db    = ResetMaxDb;
  logic signed [DbW-1:0] bin_level [NumBins] = '{default: ResetMinDb};

  out_word_t pending_levels [$];
  out_word_t want;
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  spectrum_bin_attack_release_smoother u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // new level of the addressed bin; updates the stored level
  function automatic out_word_t smooth_step(in_word_t w);
    logic [31:0] m;
    logic [63:0] f31;
    logic [63:0] x;
    logic [16:0] r;
    logic [17:0] t;
    int p;
    int idx;
    longint l2;
    longint db;
    longint prev;
    longint coef;
    longint acc;
    out_word_t o;
    o.out_bin_index = w.bin_index;
    if (w.action) begin
      o.smoothed_db = lo_db[DbW-1:0];
    end else begin
      m = (w.magnitude == '0) ? 32'd1 : w.magnitude;
      p = 31;
      while (p > 0 && !m[p]) p--;
      f31 = 64'(m - (32'd1 << p)) << (31 - p);
      idx = int'((f31 * 64'(LogSteps)) >> 31);
      if (idx >= LogSteps) idx = LogSteps - 1;
      x = ((64'(LogSteps) + 64'(idx)) << 30) / 64'(LogSteps);
      r = '0;
      for (int k = 0; k < 17; k++) begin
        x = (x * x) >> 30;
        r = {r[15:0], 1'b0};
        if (x >= 64'h8000_0000) begin
          x    = x >> 1;
          r[0] = 1'b1;
        end
      end
      t = ({1'b0, r} + 18'd1) >> 1;
      l2 = longint'(p - 16) * 65536 + longint'(t);
      db = (l2 * 394566 + (64'sd1 <<< 23)) >>> 24;
      if (db < lo_db) begin
        db = lo_db;
      end else if (db > hi_db) begin
        db = hi_db;
      end
      prev = bin_level[w.bin_index % NumBins];
      coef = (db > prev) ? attack_w : decay_w;
      acc = (coef * prev + (65536 - coef) * db + 32768) >>> 16;
      o.smoothed_db = acc[DbW-1:0];
    end
    bin_level[w.bin_index % NumBins] = o.smoothed_db;
    return o;
  endfunction

  function automatic in_word_t make_word(logic act, logic [BinW-1:0] bin, logic [MagW-1:0] mag);
    in_word_t w;
    w.action    = act;
    w.bin_index = bin;
    w.magnitude = mag;
    return w;
  endfunction

  function automatic logic [CoefW-1:0] pick_coeff();
    case ($urandom_range(5))
      0: begin
        return '0;
      end
      1: begin
        return '1;
      end
      default: begin
        return CoefW'($urandom_range(65535));
      end
    endcase
  endfunction

  function automatic logic [DbW-1:0] pick_level();
    case ($urandom_range(7))
      0: begin
        return 16'h8000;
      end
      1: begin
        return 16'h7FFF;
      end
      default: begin
        return DbW'(int'($urandom_range(28000)) - 25000);
      end
    endcase
  endfunction

  task automatic send_word(in_word_t w);
    while (send_idle_pct != 0 && int'($urandom_range(99)) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_levels.push_back(smooth_step(w));
  endtask

  task automatic send_random(int n);
    in_word_t w;
    for (int i = 0; i < n; i++) begin
      w.action = ($urandom_range(9) == 0);
      // a small pool of bins keeps levels moving and back-to-back hits frequent
      w.bin_index = ($urandom_range(3) == 0) ? BinW'($urandom_range(1023))
                                             : BinW'($urandom_range(7));
      case ($urandom_range(9))
        0: begin
          w.magnitude = '0;
        end
        1: begin
          w.magnitude = $urandom;
        end
        default: begin
          w.magnitude = $urandom >> $urandom_range(31);
        end
      endcase
      send_word(w);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic load_settings(logic [CoefW-1:0] att, logic [CoefW-1:0] dec,
                               logic [DbW-1:0] lo, logic [DbW-1:0] hi);
    drain();
    cfg_we    <= 1'b1;
    cfg_idx   <= CfgAttack;
    cfg_wdata <= att;
    @(posedge clk);
    cfg_idx   <= CfgDecay;
    cfg_wdata <= dec;
    @(posedge clk);
    cfg_idx   <= CfgMinDb;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_idx   <= CfgMaxDb;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_we   <= 1'b0;
    attack_w = att;
    decay_w  = dec;
    lo_db    = $signed(lo);
    hi_db    = $signed(hi);
  endtask

  task automatic test_directed();
    send_word(make_word(1'b0, 10'd0, 32'h0000_0000));
    send_word(make_word(1'b0, 10'd1, 32'h0000_0001));
    send_word(make_word(1'b0, 10'd2, 32'hFFFF_FFFF));
    send_word(make_word(1'b0, 10'd3, 32'h0001_0000));
    send_word(make_word(1'b0, 10'd1023, 32'h8000_0000));
    send_word(make_word(1'b0, 10'd1023, 32'h0000_0100));
    send_word(make_word(1'b0, 10'd5, 32'h0001_0000));
    send_word(make_word(1'b0, 10'd5, 32'h0000_0100));
    send_word(make_word(1'b0, 10'd5, 32'h0000_0100));
    send_word(make_word(1'b0, 10'd5, 32'h0000_0100));
    send_word(make_word(1'b1, 10'd5, 32'hFFFF_FFFF));
    send_word(make_word(1'b0, 10'd5, 32'h1234_5678));
    send_word(make_word(1'b1, 10'd1023, 32'h0000_0000));
    send_word(make_word(1'b0, 10'd1023, 32'h0000_0000));
    send_word(make_word(1'b0, 10'h2AA, 32'hAAAA_AAAA));
    send_word(make_word(1'b0, 10'h155, 32'h5555_5555));
    send_word(make_word(1'b0, 10'd4, 32'h0000_FFFF));
    send_word(make_word(1'b0, 10'd4, 32'h0001_0001));
    send_word(make_word(1'b0, 10'd512, 32'h0001_8000));
    send_word(make_word(1'b1, 10'd0, 32'h0000_0000));
    send_word(make_word(1'b0, 10'd0, 32'h7FFF_FFFF));
  endtask

  task automatic test_inverted_clamp();
    load_settings(16'd16384, 16'd49152, 16'h0000, 16'hF600);
    send_random(30);
    load_settings(16'd0, 16'd0, 16'h7FFF, 16'h8000);
    send_random(15);
  endtask

  task automatic test_coeff_extremes();
    load_settings(16'd0, 16'd0, 16'h8000, 16'h7FFF);
    send_random(15);
    load_settings(16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF);
    send_random(15);
    load_settings(16'hFFFF, 16'd0, ResetMinDb, ResetMaxDb);
    send_random(15);
    load_settings(16'd0, 16'hFFFF, 16'h8000, 16'h8000);
    send_random(15);
  endtask

  task automatic test_random_levels(int n);
    logic [DbW-1:0] a;
    logic [DbW-1:0] b;
    logic [DbW-1:0] t;
    for (int s = 0; s < 4; s++) begin
      a = pick_level();
      b = pick_level();
      if ($urandom_range(7) != 0 && $signed(a) > $signed(b)) begin
        t = a;
        a = b;
        b = t;
      end
      load_settings(pick_coeff(), pick_coeff(), a, b);
      send_random(n / 4);
    end
  endtask

  always @(posedge clk) begin
    out_ready <= (int'($urandom_range(99)) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_levels.size() == 0) begin
        errors++;
        $display("%0t: unexpected word bin %0d level %0d", $time,
                 out_word.out_bin_index, out_word.smoothed_db);
      end else begin
        want = pending_levels.pop_front();
        if (out_word.out_bin_index !== want.out_bin_index) begin
          errors++;
          $display("%0t: bin index expected %0d actual %0d", $time,
                   want.out_bin_index, out_word.out_bin_index);
        end
        if (out_word.smoothed_db !== want.smoothed_db) begin
          errors++;
          $display("%0t: level of bin %0d expected %0d actual %0d", $time,
                   want.out_bin_index, want.smoothed_db, out_word.smoothed_db);
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 22;
    recv_idle_pct = 86;
    test_directed();
    test_random_levels(400);

    send_idle_pct = 86;
    recv_idle_pct = 22;
    test_inverted_clamp();
    test_random_levels(400);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_coeff_extremes();
    test_random_levels(400);

    drain();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/sbars_pkg.sv
hw/rtl/spectrum_bin_attack_release_smoother.sv
dv/tb.sv
